### src/wsd_pkg.sv
// Shared constants, types and helpers for the WebSocket frame deframer.
`default_nettype none
package wsd_pkg;

   // Width of the payload length counter; it holds the full 64-bit extended length.
   localparam int unsigned LEN_BITS = 64;

   // Special values of the 7-bit length field.
   localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
   localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

   // Control opcodes.
   localparam logic [3:0] OP_CLOSE = 4'd8;
   localparam logic [3:0] OP_PING  = 4'd9;
   localparam logic [3:0] OP_PONG  = 4'd10;

   // One result word, without the frame-level fields.
   typedef struct packed {
      logic [7:0] payload_byte;
      logic       has_data;
      logic       last;
   } rsp_word_type;

   // Close, ping and pong are control frames.
   function automatic logic is_control(input logic [3:0] op);
      return (op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);
   endfunction

endpackage
`default_nettype wire

### src/websocket_frame_deframer.sv
// Accepted payload bytes are registered in the output register or the skid stage.
// Throughput: one stream byte per cycle while req_stall is low; header bytes produce
// no word except the byte that completes the header of an empty frame, which
// produces an empty marker. An output register and a one-word skid stage absorb
// one word under result stall; the input stalls while the skid stage holds a word.
// Reset (synchronous, active high) returns the parser to the first header byte and
// empties the output and skid stages.
`default_nettype none
module websocket_frame_deframer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_stream_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_payload_byte,
   output logic             rsp_has_data,
   output logic             rsp_last,
   output logic [3:0]       rsp_frame_opcode,
   output logic             rsp_control_frame
);
   import wsd_pkg::*;

   typedef enum logic [2:0] {
      PH_HDR0  = 3'd0,
      PH_HDR1  = 3'd1,
      PH_EXT16 = 3'd2,
      PH_EXT64 = 3'd3,
      PH_KEY   = 3'd4,
      PH_DATA  = 3'd5
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [3:0]            opcode_ff, opcode_in;
   logic                  mask_ff, mask_in;
   logic [2:0]            count_ff, count_in;
   logic [LEN_BITS-1:0]   remain_ff, remain_in;
   logic [31:0]           key_ff, key_in;
   logic [1:0]            key_idx_ff, key_idx_in;

   rsp_word_type          out_ff, out_in;
   logic [3:0]            out_op_ff, out_op_in;
   logic                  out_valid_ff, out_valid_in;
   rsp_word_type          skid_ff, skid_in;
   logic [3:0]            skid_op_ff, skid_op_in;
   logic                  skid_valid_ff, skid_valid_in;

   logic                  req_accept;
   logic                  out_take;
   logic                  res_valid;
   rsp_word_type          res;
   logic [6:0]            len7;
   logic [2:0]            final_count;
   logic [7:0]            key_byte;
   logic                  new_len_zero;

   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !skid_valid_ff;
   assign out_take   = out_valid_ff && !rsp_stall;
   assign len7       = req_stream_byte[6:0];
   assign final_count = (phase_ff == PH_EXT16) ? 3'd1 : 3'd7;
   assign key_byte   = key_ff[{~key_idx_ff, 3'b000} +: 8];

   // Header parser and payload unmasking for the accepted word.
   always_comb begin
      phase_in     = phase_ff;
      opcode_in    = opcode_ff;
      mask_in      = mask_ff;
      count_in     = count_ff;
      remain_in    = remain_ff;
      key_in       = key_ff;
      key_idx_in   = key_idx_ff;
      res_valid    = 1'b0;
      res          = '0;
      new_len_zero = 1'b0;
      if (req_accept) begin
         unique case (phase_ff)
            PH_HDR1: begin
               mask_in   = req_stream_byte[7];
               key_in    = '0;
               count_in  = '0;
               remain_in = '0;
               if (len7 == LEN_CODE_EXT16) begin
                  phase_in = PH_EXT16;
               end else if (len7 == LEN_CODE_EXT64) begin
                  phase_in = PH_EXT64;
               end else begin
                  remain_in    = LEN_BITS'(len7);
                  new_len_zero = (len7 == 7'd0);
                  if (req_stream_byte[7]) begin
                     phase_in = PH_KEY;
                  end else begin
                     key_idx_in = '0;
                     if (new_len_zero) begin
                        phase_in  = PH_HDR0;
                        res_valid = 1'b1;
                        res.last  = 1'b1;
                     end else begin
                        phase_in = PH_DATA;
                     end
                  end
               end
            end
            PH_EXT16, PH_EXT64: begin
               remain_in = {remain_ff[LEN_BITS-9:0], req_stream_byte};
               if (count_ff >= final_count) begin
                  count_in = '0;
                  if (mask_ff) begin
                     phase_in = PH_KEY;
                  end else begin
                     key_idx_in = '0;
                     if (remain_in == '0) begin
                        phase_in  = PH_HDR0;
                        res_valid = 1'b1;
                        res.last  = 1'b1;
                     end else begin
                        phase_in = PH_DATA;
                     end
                  end
               end else begin
                  count_in = count_ff + 3'd1;
               end
            end
            PH_KEY: begin
               key_in = {key_ff[23:0], req_stream_byte};
               if (count_ff >= 3'd3) begin
                  count_in   = '0;
                  key_idx_in = '0;
                  if (remain_ff == '0) begin
                     phase_in  = PH_HDR0;
                     res_valid = 1'b1;
                     res.last  = 1'b1;
                  end else begin
                     phase_in = PH_DATA;
                  end
               end else begin
                  count_in = count_ff + 3'd1;
               end
            end
            PH_DATA: begin
               key_idx_in       = key_idx_ff + 2'd1;
               remain_in        = remain_ff - LEN_BITS'(1);
               res_valid        = 1'b1;
               res.payload_byte = req_stream_byte ^ key_byte;
               res.has_data     = 1'b1;
               res.last         = (remain_ff == LEN_BITS'(1));
               if (res.last) begin
                  phase_in = PH_HDR0;
               end
            end
            default: begin
               opcode_in = req_stream_byte[3:0];
               phase_in  = PH_HDR1;
            end
         endcase
      end
   end

   // Output register with a one-word skid stage behind it.
   always_comb begin
      out_in        = out_ff;
      out_op_in     = out_op_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_op_in    = skid_op_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_in        = skid_ff;
            out_op_in     = skid_op_ff;
            skid_valid_in = 1'b0;
         end
      end else if (res_valid) begin
         if (!out_valid_ff || out_take) begin
            out_in       = res;
            out_op_in    = opcode_ff;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = res;
            skid_op_in    = opcode_ff;
            skid_valid_in = 1'b1;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   // Parser state and output stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HDR0;
         opcode_ff     <= '0;
         mask_ff       <= 1'b0;
         count_ff      <= '0;
         remain_ff     <= '0;
         key_ff        <= '0;
         key_idx_ff    <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         opcode_ff     <= opcode_in;
         mask_ff       <= mask_in;
         count_ff      <= count_in;
         remain_ff     <= remain_in;
         key_ff        <= key_in;
         key_idx_ff    <= key_idx_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff     <= out_in;
      out_op_ff  <= out_op_in;
      skid_ff    <= skid_in;
      skid_op_ff <= skid_op_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_payload_byte  = out_ff.payload_byte;
   assign rsp_has_data      = out_ff.has_data;
   assign rsp_last          = out_ff.last;
   assign rsp_frame_opcode  = out_op_ff;
   assign rsp_control_frame = is_control(out_op_ff);

endmodule
`default_nettype wire

### src/wsd_checker.sv
// Port-level checks for the WebSocket frame deframer, bound to the top level.
`default_nettype none
module wsd_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_payload_byte,
   input wire logic       rsp_has_data,
   input wire logic       rsp_last,
   input wire logic [3:0] rsp_frame_opcode,
   input wire logic       rsp_control_frame
);
   import wsd_pkg::*;

   // The control flag matches the opcode of the word.
   a_control_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_control_frame == ((rsp_frame_opcode == OP_CLOSE) ||
         (rsp_frame_opcode == OP_PING) || (rsp_frame_opcode == OP_PONG))))
      else $error("control flag does not match opcode");

   // An empty-frame marker carries a zero byte and closes its frame.
   a_empty_marker: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_has_data) |-> (rsp_last && (rsp_payload_byte == 8'd0)))
      else $error("malformed empty-frame marker");

   // Reset leaves no word on the result port.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word present after reset");

   // A stalled word holds until it is taken.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_payload_byte) &&
         $stable(rsp_last) && $stable(rsp_frame_opcode)))
      else $error("stalled result word changed");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_payload_byte  (rsp_payload_byte),
   .rsp_has_data      (rsp_has_data),
   .rsp_last          (rsp_last),
   .rsp_frame_opcode  (rsp_frame_opcode),
   .rsp_control_frame (rsp_control_frame)
);
`default_nettype wire
